@@ hdl/ridr_pkg.sv @@
// Shared package for the recent-ID de-duplicating ring.
// Holds sizing constants, operation codes, the sequencer states and the cell control struct.
// Used by ridr_cell and recent_id_dedup_ring_top; it depends on nothing else.
package ridr_pkg;

    // Ring sizing.
    localparam int DEPTH   = 32;
    localparam int ID_BITS = 16;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);

    typedef logic [ID_BITS-1:0] id_t;
    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [CNT_W-1:0]   cnt_t;

    // Operation codes of a request.
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_QUERY  = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMPARE,
        ST_APPLY
    } state_t;

    // Control that the sequencer hands to every cell.
    typedef struct packed {
        logic compare;  // capture the match flag of this cell
        logic shift;    // take the ID of the next newer cell
        logic load;     // take the new ID
        logic valid;    // this cell lies below the entry count
    } cell_ctl_t;

endpackage

@@ hdl/ridr_cell.sv @@
// One cell of the ring: holds one stored ID and its registered match flag.
// Cells form a chain ordered from oldest to newest; an eviction shifts every ID one cell down.
// Depends on ridr_pkg.
module ridr_cell (
    input  logic                clk,
    input  ridr_pkg::cell_ctl_t ctl,
    input  ridr_pkg::id_t       cmp_id,
    input  ridr_pkg::id_t       new_id,
    input  ridr_pkg::id_t       newer_value,
    output ridr_pkg::id_t       value,
    output logic                hit
);
    import ridr_pkg::*;

    id_t  value_reg;
    id_t  value_next;
    logic hit_reg;
    logic hit_next;

    // Stored ID: shift from the newer neighbor, load a new ID, or hold.
    always_comb
    begin
        value_next = value_reg;
        if (ctl.shift)
        begin
            value_next = newer_value;
        end
        else if (ctl.load)
        begin
            value_next = new_id;
        end
    end

    // Match flag: only a cell that holds a live entry can match.
    always_comb
    begin
        hit_next = hit_reg;
        if (ctl.compare)
        begin
            hit_next = ctl.valid && (value_reg == cmp_id);
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        hit_reg   <= hit_next;
    end

    assign value = value_reg;
    assign hit   = hit_reg;

endmodule

@@ hdl/recent_id_dedup_ring_top.sv @@
// Recent-ID de-duplicating ring: a chain of DEPTH cells from oldest to newest.
// Timing: a request is captured on acceptance, then passes the compare and apply states; done is registered from apply.
// A new request is not taken until the sequencer is back in idle; busy is high in the compare and apply states.
// The sequencer runs compare (every cell matches in parallel) then apply (update and result).
// Reset clears the entry count, the sequencer and the result strobe; stored IDs are not cleared.
// Results cannot be stalled: each appears for one cycle with done high.
module recent_id_dedup_ring_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  ridr_pkg::op_t       operation,
    input  ridr_pkg::id_t       node_id,
    input  ridr_pkg::idx_t      position,
    output logic                done,
    output logic                found,
    output logic                evicted,
    output logic                read_valid,
    output ridr_pkg::id_t       read_value,
    output ridr_pkg::cnt_t      entry_count
);
    import ridr_pkg::*;

    state_t state_reg;
    state_t state_next;

    op_t  cmd_op_reg;
    id_t  cmd_id_reg;
    idx_t cmd_pos_reg;

    cnt_t count_reg;
    cnt_t count_next;

    logic done_reg;
    logic done_next;
    logic found_reg;
    logic found_next;
    logic evicted_reg;
    logic evicted_next;
    logic read_valid_reg;
    logic read_valid_next;
    id_t  read_value_reg;
    id_t  read_value_next;

    logic accept;
    logic any_hit;
    logic full;
    logic do_append;
    logic do_shift;
    logic do_compare;
    logic pos_in_range;

    id_t         cell_value [DEPTH];
    logic [DEPTH-1:0] cell_hit;
    cell_ctl_t   cell_ctl   [DEPTH];

    assign accept  = start && !busy;
    assign any_hit = |cell_hit;
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign pos_in_range = (CNT_W'(cmd_pos_reg) < count_reg);

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_COMPARE;
                end
            end
            ST_COMPARE: state_next = ST_APPLY;
            ST_APPLY:   state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        busy       = 1'b1;
        do_compare = 1'b0;
        do_append  = 1'b0;
        do_shift   = 1'b0;
        done_next  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
            end
            ST_COMPARE:
            begin
                do_compare = 1'b1;
            end
            ST_APPLY:
            begin
                done_next = 1'b1;
                if ((cmd_op_reg == OP_INSERT) && !any_hit)
                begin
                    do_append = !full;
                    do_shift  = full;
                end
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    // Result fields and the new entry count.
    always_comb
    begin
        count_next      = count_reg;
        found_next      = found_reg;
        evicted_next    = evicted_reg;
        read_valid_next = read_valid_reg;
        read_value_next = read_value_reg;
        if (state_reg == ST_APPLY)
        begin
            found_next      = 1'b0;
            evicted_next    = do_shift;
            read_valid_next = 1'b0;
            read_value_next = '0;
            case (cmd_op_reg)
                OP_INSERT:
                begin
                    found_next = any_hit;
                    if (do_append)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                OP_QUERY:
                begin
                    found_next = any_hit;
                end
                OP_CLEAR:
                begin
                    count_next = '0;
                end
                OP_READ:
                begin
                    if (pos_in_range)
                    begin
                        read_valid_next = 1'b1;
                        read_value_next = cell_value[cmd_pos_reg];
                    end
                end
                default:
                begin
                    found_next = 1'b0;
                end
            endcase
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Request capture and result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_op_reg  <= operation;
            cmd_id_reg  <= node_id;
            cmd_pos_reg <= position;
        end
        found_reg      <= found_next;
        evicted_reg    <= evicted_next;
        read_valid_reg <= read_valid_next;
        read_value_reg <= read_value_next;
    end

    // Chain of cells, oldest at index 0; the newest cell shifts in the new ID.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        id_t newer;

        if (i == DEPTH - 1)
        begin : g_top
            assign newer = cmd_id_reg;
        end
        else
        begin : g_mid
            assign newer = cell_value[i+1];
        end

        assign cell_ctl[i].compare = do_compare;
        assign cell_ctl[i].shift   = do_shift;
        assign cell_ctl[i].load    = do_append && (count_reg == CNT_W'(i));
        assign cell_ctl[i].valid   = (CNT_W'(i) < count_reg);

        ridr_cell u_cell (
            .clk         (clk),
            .ctl         (cell_ctl[i]),
            .cmp_id      (cmd_id_reg),
            .new_id      (cmd_id_reg),
            .newer_value (newer),
            .value       (cell_value[i]),
            .hit         (cell_hit[i])
        );
    end

    assign done        = done_reg;
    assign found       = found_reg;
    assign evicted     = evicted_reg;
    assign read_valid  = read_valid_reg;
    assign read_value  = read_value_reg;
    assign entry_count = count_reg;

    // A result strobe only follows the apply step.
    a_done_after_apply: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg) == ST_APPLY)
        else $error("result strobe without an apply step");

    // The entry count never exceeds the ring depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above ring depth");

    // An eviction is reported only with a full ring.
    a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && evicted) |-> (count_reg == CNT_W'(DEPTH)))
        else $error("eviction reported while ring not full");

    // An accepted request always moves the sequencer to the compare step.
    a_accept_compare: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_COMPARE)
        else $error("accepted request did not start a compare");

endmodule
